// ----- sv/hgch_pkg.sv -----
`timescale 1ns / 1ps

package hgch_pkg;

    // Defaults for the top-level parameters
    localparam int REGIONS_DEF    = 9;
    localparam int COUNT_BITS_DEF = 24;

    // Fixed field widths
    localparam int OP_W        = 2;
    localparam int RGB_W       = 8;
    localparam int REGION_W    = 4;
    localparam int CLASS_W     = 5;
    localparam int CLASSES     = 32;
    localparam int BIN_W       = 9;
    localparam int COUNT_OUT_W = 24;
    localparam int TOTAL_W     = 28;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ_BIN   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_TOTAL = 2'd2;

endpackage

// ----- sv/hgch_ram.sv -----
`timescale 1ns / 1ps

module hgch_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 288,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/hgch_classify.sv -----
`timescale 1ns / 1ps

module hgch_classify
    import hgch_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [RGB_W-1:0]   red,
    input  logic [RGB_W-1:0]   green,
    input  logic [RGB_W-1:0]   blue,
    output logic [CLASS_W-1:0] color_class
);

    // V thresholds on max (0.2, 0.5, 0.8 of full scale)
    localparam logic [RGB_W-1:0] V_BLACK_MAX = 8'd51;
    localparam logic [RGB_W-1:0] V_HALF_MAX  = 8'd127;
    localparam logic [RGB_W-1:0] V_HIGH_MAX  = 8'd204;

    // Hue band edges in degrees divided by 5, against 12 * hue sector sum
    localparam int HUE_W = 15;
    localparam logic [HUE_W-1:0] H20  = 15'd4;
    localparam logic [HUE_W-1:0] H45  = 15'd9;
    localparam logic [HUE_W-1:0] H75  = 15'd15;
    localparam logic [HUE_W-1:0] H165 = 15'd33;
    localparam logic [HUE_W-1:0] H200 = 15'd40;
    localparam logic [HUE_W-1:0] H270 = 15'd54;
    localparam logic [HUE_W-1:0] H330 = 15'd66;

    localparam int X_W = 11;

    logic [RGB_W-1:0] mx;
    logic [RGB_W-1:0] mn;
    logic [RGB_W-1:0] delta;
    logic [X_W-1:0]   hx;

    logic [RGB_W-1:0] mx_reg;
    logic [RGB_W-1:0] delta_reg;
    logic [X_W-1:0]   hx_reg;

    logic [HUE_W-1:0] hx12;
    logic [HUE_W-1:0] d_ext;
    logic [11:0]      delta10;
    logic [12:0]      delta20;
    logic [12:0]      mx9;
    logic [2:0]       band;
    logic             sat_hi;
    logic             val_hi;

    // Max, min and the hue sector sum hx = H * delta / 60, always in [0, 6*delta]
    always_comb
    begin
        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        delta = mx - mn;

        if (red == mx)
        begin
            if (green >= blue)
            begin
                hx = X_W'(green - blue);
            end
            else
            begin
                hx = 11'd6 * X_W'(delta) - X_W'(blue - green);
            end
        end
        else if (green == mx)
        begin
            hx = (11'd2 * X_W'(delta) + X_W'(blue)) - X_W'(red);
        end
        else
        begin
            hx = (11'd4 * X_W'(delta) + X_W'(red)) - X_W'(green);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg    <= mx;
            delta_reg <= delta;
            hx_reg    <= hx;
        end
    end

    assign hx12    = 15'd12 * HUE_W'(hx_reg);
    assign d_ext   = HUE_W'(delta_reg);
    assign delta10 = 12'd10 * 12'(delta_reg);
    assign delta20 = 13'd20 * 13'(delta_reg);
    assign mx9     = 13'd9 * 13'(mx_reg);
    assign sat_hi  = delta20 > mx9;
    assign val_hi  = mx_reg > V_HALF_MAX;

    // Bands are closed at the top edge
    always_comb
    begin
        priority if (hx12 <= H20 * d_ext || hx12 > H330 * d_ext)
        begin
            band = 3'd0;
        end
        else if (hx12 <= H45 * d_ext)
        begin
            band = 3'd1;
        end
        else if (hx12 <= H75 * d_ext)
        begin
            band = 3'd2;
        end
        else if (hx12 <= H165 * d_ext)
        begin
            band = 3'd3;
        end
        else if (hx12 <= H200 * d_ext)
        begin
            band = 3'd4;
        end
        else if (hx12 <= H270 * d_ext)
        begin
            band = 3'd5;
        end
        else
        begin
            band = 3'd6;
        end
    end

    always_comb
    begin
        priority if (mx_reg <= V_BLACK_MAX)
        begin
            color_class = 5'd0;
        end
        else if (delta10 <= 12'(mx_reg))
        begin
            if (mx_reg <= V_HALF_MAX)
            begin
                color_class = 5'd1;
            end
            else if (mx_reg <= V_HIGH_MAX)
            begin
                color_class = 5'd2;
            end
            else
            begin
                color_class = 5'd3;
            end
        end
        else
        begin
            color_class = {band + 3'd1, sat_hi, val_hi};
        end
    end

endmodule

// ----- sv/hsv_grid_color_histogram_unit.sv -----
`timescale 1ns / 1ps

// HSV colour histogram over a grid of regions. Each beat on the slave side
// carries an operation in s_tuser: accumulate a pixel (sort it into one of
// 32 colour classes and, if its region is below REGIONS, bump the bin
// region*32+class and the pixel total, both saturating), read and clear
// one bin, or read and clear the total. Every accepted beat gives exactly
// one result beat on the master side. The bins live in one synchronous
// RAM; a pixel flows through a colour stage, which issues the RAM read, and
// a modify/write-back stage into the output register, so one beat per
// cycle is taken when the master side does not stall. A write-back to the
// bin that the following beat is reading in the same cycle is forwarded
// from a register. After reset the block sweeps the RAM to zero, one bin
// per cycle over all REGIONS*32 bins (288 at the default), and holds
// s_tready low until the sweep is done.
module hsv_grid_color_histogram_unit
    import hgch_pkg::*;
#(
    parameter int REGIONS    = REGIONS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // red[7:0], green[15:8], blue[23:16], region[27:24], bin_select[36:28]
    input  logic [39:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bin_used[8:0], bin_count[32:9], pixel_total[60:33]
    output logic [63:0] m_tdata
);

    localparam int NBINS = REGIONS * CLASSES;
    localparam int IDX_W = $clog2(NBINS);

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_ACC   = 2'd1;
    localparam logic [1:0] KIND_BIN   = 2'd2;
    localparam logic [1:0] KIND_TOTAL = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;

    // Input fields
    logic [OP_W-1:0]     in_op;
    logic [RGB_W-1:0]    in_red;
    logic [RGB_W-1:0]    in_green;
    logic [RGB_W-1:0]    in_blue;
    logic [REGION_W-1:0] in_region;
    logic [BIN_W-1:0]    in_sel;

    logic adv;
    logic accept;
    logic commit;

    // Clearing sweep
    logic [IDX_W-1:0] clr_cnt_reg;
    logic             clr_done_reg;

    // Colour stage
    logic                s1_valid_reg;
    logic [OP_W-1:0]     s1_op_reg;
    logic [REGION_W-1:0] s1_region_reg;
    logic [BIN_W-1:0]    s1_sel_reg;
    logic [CLASS_W-1:0]  s1_class;
    logic [1:0]          s1_kind;
    logic [BIN_W-1:0]    s1_used;
    logic                s1_hit;

    // Write-back stage
    logic               s2_valid_reg;
    logic [1:0]         s2_kind_reg;
    logic [BIN_W-1:0]   s2_used_reg;
    logic               s2_hit_reg;
    logic [IDX_W-1:0]   s2_addr;
    logic [COUNT_BITS-1:0] s2_old;
    logic [COUNT_BITS-1:0] s2_wdata;
    logic               s2_we;
    logic [COUNT_BITS-1:0] s2_count;
    logic [BIN_W-1:0]   s2_used_out;
    logic [TOTAL_W-1:0] s2_total_out;
    logic [TOTAL_W-1:0] total_next;

    logic [TOTAL_W-1:0] total_reg;

    // Last write-back, for the read that raced it
    logic                  fwd_valid_reg;
    logic [IDX_W-1:0]      fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    // RAM ports
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [COUNT_BITS-1:0] ram_rdata;

    // Output register
    logic                   m_valid_reg;
    logic [BIN_W-1:0]       out_used_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic [TOTAL_W-1:0]     out_total_reg;

    assign in_red    = s_tdata[7:0];
    assign in_green  = s_tdata[15:8];
    assign in_blue   = s_tdata[23:16];
    assign in_region = s_tdata[27:24];
    assign in_sel    = s_tdata[36:28];
    assign in_op     = s_tuser;

    // The whole pipe advances together whenever the output register frees up
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv && clr_done_reg;
    assign accept   = s_tvalid && s_tready;
    assign commit   = adv && s2_valid_reg;

    // Sweep every bin to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == IDX_W'(NBINS - 1))
            begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    hgch_classify u_classify (
        .clk         (clk),
        .en          (accept),
        .red         (in_red),
        .green       (in_green),
        .blue        (in_blue),
        .color_class (s1_class)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= in_op;
            s1_region_reg <= in_region;
            s1_sel_reg    <= in_sel;
        end
    end

    // Decode the beat into what the write-back stage must do
    always_comb
    begin
        unique case (s1_op_reg)
            OP_ACCUMULATE:
            begin
                s1_hit  = {1'b0, s1_region_reg} < (REGION_W + 1)'(REGIONS);
                s1_kind = s1_hit ? KIND_ACC : KIND_NONE;
                s1_used = s1_hit ? {s1_region_reg, s1_class} : '0;
            end
            OP_READ_BIN:
            begin
                s1_hit  = {1'b0, s1_sel_reg} < (BIN_W + 1)'(NBINS);
                s1_kind = KIND_BIN;
                s1_used = s1_sel_reg;
            end
            OP_READ_TOTAL:
            begin
                s1_hit  = 1'b0;
                s1_kind = KIND_TOTAL;
                s1_used = '0;
            end
            default:
            begin
                s1_hit  = 1'b0;
                s1_kind = KIND_NONE;
                s1_used = '0;
            end
        endcase
    end

    // Issue the bin read as the beat moves into write-back
    assign ram_re = adv && s1_valid_reg && s1_hit;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_kind_reg <= s1_kind;
            s2_used_reg <= s1_used;
            s2_hit_reg  <= s1_hit;
        end
    end

    assign s2_addr = s2_used_reg[IDX_W-1:0];
    assign s2_old  = (fwd_valid_reg && fwd_addr_reg == s2_addr) ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        s2_we        = 1'b0;
        s2_wdata     = '0;
        s2_count     = '0;
        s2_used_out  = '0;
        s2_total_out = total_reg;
        total_next   = total_reg;
        unique case (s2_kind_reg)
            KIND_ACC:
            begin
                s2_we        = 1'b1;
                s2_wdata     = (s2_old == COUNT_MAX) ? s2_old : s2_old + 1'b1;
                s2_count     = s2_wdata;
                s2_used_out  = s2_used_reg;
                total_next   = (total_reg == TOTAL_MAX) ? total_reg : total_reg + 1'b1;
                s2_total_out = total_next;
            end
            KIND_BIN:
            begin
                s2_we       = s2_hit_reg;
                s2_count    = s2_hit_reg ? s2_old : '0;
                s2_used_out = s2_used_reg;
            end
            KIND_TOTAL:
            begin
                total_next = '0;
            end
            default:
            begin
                s2_we = 1'b0;
            end
        endcase
    end

    // The sweep and the pipe never overlap: no beat enters before it ends
    assign ram_we    = !clr_done_reg || (commit && s2_we);
    assign ram_waddr = clr_done_reg ? s2_addr : clr_cnt_reg;
    assign ram_wdata = clr_done_reg ? s2_wdata : '0;

    hgch_ram #(
        .WIDTH  (COUNT_BITS),
        .DEPTH  (NBINS),
        .ADDR_W (IDX_W)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (s1_used[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
                m_valid_reg  <= s2_valid_reg;
            end
            if (commit)
            begin
                total_reg <= total_next;
                if (s2_we)
                begin
                    fwd_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_used_reg  <= s2_used_out;
            out_count_reg <= COUNT_OUT_W'(s2_count);
            out_total_reg <= s2_total_out;
            if (s2_we)
            begin
                fwd_addr_reg <= s2_addr;
                fwd_data_reg <= s2_wdata;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_total_reg, out_count_reg, out_used_reg};

    // No beat may be in flight while the sweep still runs
    a_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done_reg |-> (!s_tready && !s1_valid_reg && !s2_valid_reg))
        else $error("beat in flight during bin sweep");

    // Once finished, the sweep never restarts
    a_sweep_once: assert property (@(posedge clk) disable iff (!rst_n)
        clr_done_reg |=> clr_done_reg)
        else $error("bin sweep restarted");

    // An accumulated pixel bumps an unsaturated total by exactly one
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && s2_kind_reg == KIND_ACC && total_reg != TOTAL_MAX)
        |=> total_reg == $past(total_reg) + 1'b1)
        else $error("pixel total did not advance by one");

endmodule
